// File: rtl/sdtd_pkg.sv
package sdtd_pkg;

    localparam int WindowLenDef = 256;
    localparam int BlockLenDef  = 32;

    localparam int SampleW  = 8;
    localparam int GainW    = 31;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;
    localparam int DecimW   = 8;
    localparam int BcW      = 8;
    localparam int StateW   = 32;
    localparam int CombW    = 18;
    localparam int MulW     = 33;
    localparam int ProdW    = 2 * MulW;
    localparam int WsumW    = 35;
    localparam int SqW      = 64;
    localparam int MagW     = 32;
    localparam int DiffW    = 34;
    localparam int NumRes   = 6;
    localparam int ResIdxW  = 3;

    typedef enum logic [2:0] {
        MUL_BRSR = 3'd0,
        MUL_BISI = 3'd1,
        MUL_BRSI = 3'd2,
        MUL_BISR = 3'd3,
        MUL_CRR  = 3'd4,
        MUL_CII  = 3'd5
    } t_mul;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_COMB_GAIN   = 3'd0,
        CFG_LOW_BELOW   = 3'd1,
        CFG_LOW_CENTER  = 3'd2,
        CFG_LOW_ABOVE   = 3'd3,
        CFG_HIGH_BELOW  = 3'd4,
        CFG_HIGH_CENTER = 3'd5,
        CFG_HIGH_ABOVE  = 3'd6,
        CFG_DECIMATION  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               take;
        logic               comb;
        t_mul               mul_sel;
        logic               acc_load;
        logic               re_calc;
        logic               im_calc;
        logic               sq_start;
        logic               mag_store;
        logic               finish;
        logic [ResIdxW-1:0] k;
        logic               tone;
    } t_cmd;

    typedef struct packed {
        logic sqrt_busy;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/sliding_dft_two_tone_detector.sv
// Two-tone detector on a damped sliding DFT.
// Input channel: i_in_valid / o_in_stall with i_sample; one transfer per sample.
// Output channel: o_out_valid / i_out_stall; exactly one result per sample
// (tone bit always, level difference with block flags on decimated samples).
// Config: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index picks the
// register, i_cfg_data carries it; write only while the block is idle.
// Each sample passes in turn through the single shared 33x33 multiplier
// (six resonators, then the squares of both tones) and the one-bit-per-cycle
// square root, run once per tone; a new sample is taken only after the
// previous one has finished.
// The result sits in an output register, so the next sample is taken while
// it waits; a stalled receiver only holds the block once a second result is
// ready to load.
// Reset: synchronous, active low; clears resonators, counters, buffer toggle
// and config to defaults. The delay line needs no clearing pass: its entries
// read as zero until the write index has wrapped once.
module sliding_dft_two_tone_detector import sdtd_pkg::*; #(
    parameter int WINDOW_LEN = WindowLenDef,
    parameter int BLOCK_LEN  = BlockLenDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [SampleW-1:0]      i_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_tone_high,
    output logic                    o_diff_valid,
    output logic signed [DiffW-1:0] o_level_diff,
    output logic                    o_block_end,
    output logic                    o_buffer_select,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CfgIdxW-1:0]      i_cfg_index,
    input  logic [CfgDataW-1:0]     i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic idle;

    // config is single-cycle, never back-pressured
    assign o_cfg_ready = 1'b1;
    // a new sample is only taken between samples
    assign o_in_stall  = !idle;

    sdtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_idle     (idle),
        .o_cmd      (cmd)
    );

    sdtd_dp #(
        .WINDOW_LEN (WINDOW_LEN),
        .BLOCK_LEN  (BLOCK_LEN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample        (i_sample),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_tone_high     (o_tone_high),
        .o_diff_valid    (o_diff_valid),
        .o_level_diff    (o_level_diff),
        .o_block_end     (o_block_end),
        .o_buffer_select (o_buffer_select)
    );

endmodule

// File: rtl/sdtd_ram.sv
module sdtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// File: rtl/sdtd_sqrt.sv
module sdtd_sqrt import sdtd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SqW-1:0]  i_value,
    output logic            o_busy,
    output logic [MagW-1:0] o_root
);

    // one result bit per cycle, restoring form
    localparam logic [SqW-1:0] BitTop = {2'b01, {(SqW-2){1'b0}}};

    logic [SqW-1:0] r_v, r_r, r_bit;
    logic [SqW-1:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= BitTop;
        end else if (r_bit != '0) begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_value;
            r_r <= '0;
        end else if (r_bit != '0) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
        end
    end

    assign o_busy = (r_bit != '0);
    assign o_root = r_r[MagW-1:0];

endmodule

// File: rtl/sdtd_dp.sv
module sdtd_dp import sdtd_pkg::*; #(
    parameter int WINDOW_LEN = WindowLenDef,
    parameter int BLOCK_LEN  = BlockLenDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxW-1:0]      i_cfg_index,
    input  logic [CfgDataW-1:0]     i_cfg_data,
    input  logic [SampleW-1:0]      i_sample,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic                    o_tone_high,
    output logic                    o_diff_valid,
    output logic signed [DiffW-1:0] o_level_diff,
    output logic                    o_block_end,
    output logic                    o_buffer_select
);

    localparam int AddrW = $clog2(WINDOW_LEN);
    localparam int GpW   = GainW + SampleW;
    localparam int SumW  = ProdW + 1;
    localparam logic [AddrW-1:0]      LastIdx = AddrW'(WINDOW_LEN - 1);
    localparam logic [BcW:0]          BlkLim  = (BcW + 1)'(BLOCK_LEN);
    localparam logic [GainW-1:0]      GainOne = {1'b1, {(GainW-1){1'b0}}};
    localparam logic [GpW-1:0]        CombRnd = GpW'(1) << 21;
    localparam logic signed [SumW-1:0] ResRnd = SumW'(1) <<< 29;
    localparam logic signed [StateW-1:0] SMax = {1'b0, {(StateW-1){1'b1}}};
    localparam logic signed [StateW-1:0] SMin = {1'b1, {(StateW-1){1'b0}}};

    // configuration
    logic [GainW-1:0]    r_gain;
    logic [CfgDataW-1:0] r_coef [NumRes];
    logic [DecimW-1:0]   r_decim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GainOne;
            r_decim <= DecimW'(1);
            for (int i = 0; i < NumRes; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COMB_GAIN:   r_gain    <= i_cfg_data[GainW-1:0];
                CFG_LOW_BELOW:   r_coef[0] <= i_cfg_data;
                CFG_LOW_CENTER:  r_coef[1] <= i_cfg_data;
                CFG_LOW_ABOVE:   r_coef[2] <= i_cfg_data;
                CFG_HIGH_BELOW:  r_coef[3] <= i_cfg_data;
                CFG_HIGH_CENTER: r_coef[4] <= i_cfg_data;
                CFG_HIGH_ABOVE:  r_coef[5] <= i_cfg_data;
                CFG_DECIMATION:  r_decim   <= i_cfg_data[DecimW-1:0];
                default: ;
            endcase
        end
    end

    // delay line; entries count as zero until the index has wrapped once
    logic [SampleW-1:0] r_x;
    logic [AddrW-1:0]   r_idx;
    logic               r_full;
    logic [SampleW-1:0] ram_q, old;

    sdtd_ram #(
        .WIDTH (SampleW),
        .DEPTH (WINDOW_LEN)
    ) u_delay (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish),
        .i_waddr (r_idx),
        .i_wdata (r_x),
        .i_re    (i_cmd.take),
        .i_raddr (r_idx),
        .o_rdata (ram_q)
    );

    assign old = r_full ? ram_q : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_x <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_full <= 1'b0;
        end else if (i_cmd.finish) begin
            if (r_idx == LastIdx) begin
                r_idx  <= '0;
                r_full <= 1'b1;
            end else begin
                r_idx <= r_idx + AddrW'(1);
            end
        end
    end

    // comb
    logic [GpW-1:0]          gprod;
    logic signed [CombW-1:0] r_comb;

    assign gprod = (GpW'(r_gain) * GpW'(old)) + CombRnd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.comb) begin
            r_comb <= $signed({1'b0, r_x, 8'b0}) - $signed({1'b0, gprod[GpW-1:22]});
        end
    end

    // shared multiplier
    logic signed [StateW-1:0] r_sr [NumRes];
    logic signed [StateW-1:0] r_si [NumRes];
    logic signed [StateW-1:0] br, bi, sr, si;
    logic signed [WsumW-1:0]  r_ws_re [2];
    logic signed [WsumW-1:0]  r_ws_im [2];
    logic signed [WsumW-1:0]  qre, qim;
    logic signed [MulW-1:0]   ma, mb;
    logic signed [ProdW-1:0]  r_prod, r_acc;

    assign br  = $signed(r_coef[i_cmd.k][CfgDataW-1:StateW]);
    assign bi  = $signed(r_coef[i_cmd.k][StateW-1:0]);
    assign sr  = r_sr[i_cmd.k];
    assign si  = r_si[i_cmd.k];
    assign qre = (r_ws_re[i_cmd.tone] + WsumW'(2)) >>> 2;
    assign qim = (r_ws_im[i_cmd.tone] + WsumW'(2)) >>> 2;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_BRSR: begin ma = MulW'(br); mb = MulW'(sr); end
            MUL_BISI: begin ma = MulW'(bi); mb = MulW'(si); end
            MUL_BRSI: begin ma = MulW'(br); mb = MulW'(si); end
            MUL_BISR: begin ma = MulW'(bi); mb = MulW'(sr); end
            MUL_CRR:  begin ma = qre[MulW-1:0]; mb = qre[MulW-1:0]; end
            MUL_CII:  begin ma = qim[MulW-1:0]; mb = qim[MulW-1:0]; end
            default:  begin ma = MulW'(br); mb = MulW'(sr); end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        if (i_cmd.acc_load) begin
            r_acc <= r_prod;
        end
    end

    // resonator update: round half up by 2^30, add comb, saturate
    logic signed [SumW-1:0]   dsum, tot;
    logic signed [StateW-1:0] res_val;
    logic signed [StateW-1:0] r_nre;

    always_comb begin
        if (i_cmd.re_calc) begin
            dsum = SumW'(r_acc) - SumW'(r_prod);
        end else begin
            dsum = SumW'(r_acc) + SumW'(r_prod);
        end
        tot = ((dsum + ResRnd) >>> 30) + SumW'(r_comb);
        if (tot > SumW'(SMax)) begin
            res_val = SMax;
        end else if (tot < SumW'(SMin)) begin
            res_val = SMin;
        end else begin
            res_val = tot[StateW-1:0];
        end
    end

    // Hann weighting -1/4, 1/2, -1/4 accumulated as -1, 2, -1
    logic                    wt, centre, first;
    logic signed [WsumW-1:0] vre, vim, tre, tim;

    assign wt     = (i_cmd.k >= ResIdxW'(3));
    assign centre = (i_cmd.k == ResIdxW'(1)) || (i_cmd.k == ResIdxW'(4));
    assign first  = (i_cmd.k == ResIdxW'(0)) || (i_cmd.k == ResIdxW'(3));
    assign vre    = WsumW'(r_nre);
    assign vim    = WsumW'(res_val);
    assign tre    = centre ? (vre <<< 1) : -vre;
    assign tim    = centre ? (vim <<< 1) : -vim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumRes; i++) begin
                r_sr[i] <= '0;
                r_si[i] <= '0;
            end
        end else if (i_cmd.im_calc) begin
            r_sr[i_cmd.k] <= r_nre;
            r_si[i_cmd.k] <= res_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.re_calc) begin
            r_nre <= res_val;
        end
        if (i_cmd.im_calc) begin
            r_ws_re[wt] <= first ? tre : r_ws_re[wt] + tre;
            r_ws_im[wt] <= first ? tim : r_ws_im[wt] + tim;
        end
    end

    // magnitude
    logic [SqW-1:0]  sq;
    logic [MagW-1:0] root;
    logic            sqrt_busy;
    logic [MagW-1:0] r_mag [2];

    assign sq = r_acc[SqW-1:0] + r_prod[SqW-1:0];

    sdtd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start),
        .i_value (sq),
        .o_busy  (sqrt_busy),
        .o_root  (root)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mag_store) begin
            r_mag[i_cmd.tone] <= root;
        end
    end

    // decimation, block count and output register
    logic signed [DiffW-1:0] diff;
    logic [DecimW-1:0]       dec;
    logic [DecimW:0]         ph1;
    logic [BcW:0]            bc1;
    logic                    emit, blk_end;
    logic [DecimW-1:0]       r_phase;
    logic [BcW-1:0]          r_bc;
    logic                    r_buf;
    logic                    r_ovalid, r_tone, r_dvalid, r_bend, r_bsel;
    logic signed [DiffW-1:0] r_ldiff;

    assign diff    = $signed({2'b00, r_mag[1]}) - $signed({2'b00, r_mag[0]});
    assign dec     = (r_decim == '0) ? DecimW'(1) : r_decim;
    assign emit    = (r_phase == '0);
    assign ph1     = {1'b0, r_phase} + (DecimW + 1)'(1);
    assign bc1     = {1'b0, r_bc} + (BcW + 1)'(1);
    assign blk_end = emit && (bc1 >= BlkLim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_bc    <= '0;
            r_buf   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_phase <= (ph1 >= {1'b0, dec}) ? '0 : ph1[DecimW-1:0];
            if (emit) begin
                r_bc <= blk_end ? '0 : bc1[BcW-1:0];
                if (blk_end) begin
                    r_buf <= ~r_buf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_tone   <= (diff > 0);
            r_dvalid <= emit;
            r_ldiff  <= emit ? diff : '0;
            r_bend   <= blk_end;
            r_bsel   <= emit & r_buf;
        end
    end

    assign o_sts.sqrt_busy = sqrt_busy;
    assign o_sts.out_free  = !r_ovalid || !i_out_stall;

    assign o_out_valid     = r_ovalid;
    assign o_tone_high     = r_tone;
    assign o_diff_valid    = r_dvalid;
    assign o_level_diff    = r_ldiff;
    assign o_block_end     = r_bend;
    assign o_buffer_select = r_bsel;

endmodule

// File: rtl/sdtd_ctrl.sv
module sdtd_ctrl import sdtd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_idle,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_COMB = 6'b000010,
        S_RES  = 6'b000100,
        S_MAG  = 6'b001000,
        S_SQRT = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    localparam logic [2:0]         StepLast = 3'd4;
    localparam logic [ResIdxW-1:0] ResLast  = ResIdxW'(NumRes - 1);

    t_state             r_state, n_state;
    logic [ResIdxW-1:0] r_k, n_k;
    logic [2:0]         r_s, n_s;
    logic [1:0]         r_m, n_m;
    logic               r_t, n_t;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_s     = r_s;
        n_m     = r_m;
        n_t     = r_t;
        o_cmd           = '0;
        o_cmd.mul_sel   = MUL_BRSR;
        o_cmd.k         = r_k;
        o_cmd.tone      = r_t;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_COMB;
                end
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_k        = '0;
                n_s        = '0;
                n_state    = S_RES;
            end
            S_RES: begin
                case (r_s)
                    3'd0: o_cmd.mul_sel = MUL_BRSR;
                    3'd1: begin
                        o_cmd.mul_sel  = MUL_BISI;
                        o_cmd.acc_load = 1'b1;
                    end
                    3'd2: begin
                        o_cmd.mul_sel = MUL_BRSI;
                        o_cmd.re_calc = 1'b1;
                    end
                    3'd3: begin
                        o_cmd.mul_sel  = MUL_BISR;
                        o_cmd.acc_load = 1'b1;
                    end
                    default: o_cmd.im_calc = 1'b1;
                endcase
                if (r_s == StepLast) begin
                    n_s = '0;
                    if (r_k == ResLast) begin
                        n_t     = 1'b0;
                        n_m     = '0;
                        n_state = S_MAG;
                    end else begin
                        n_k = r_k + ResIdxW'(1);
                    end
                end else begin
                    n_s = r_s + 3'd1;
                end
            end
            S_MAG: begin
                case (r_m)
                    2'd0: o_cmd.mul_sel = MUL_CRR;
                    2'd1: begin
                        o_cmd.mul_sel  = MUL_CII;
                        o_cmd.acc_load = 1'b1;
                    end
                    default: begin
                        o_cmd.sq_start = 1'b1;
                        n_state        = S_SQRT;
                    end
                endcase
                n_m = r_m + 2'd1;
            end
            S_SQRT: begin
                if (!i_sts.sqrt_busy) begin
                    o_cmd.mag_store = 1'b1;
                    if (r_t) begin
                        n_state = S_FIN;
                    end else begin
                        n_t     = 1'b1;
                        n_m     = '0;
                        n_state = S_MAG;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_s     <= '0;
            r_m     <= '0;
            r_t     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_s     <= n_s;
            r_m     <= n_m;
            r_t     <= n_t;
        end
    end

    assign o_idle = (r_state == S_IDLE);

`ifndef ASSERT_OFF
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("result loaded while output register occupied");

    a_sq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sq_start |-> !i_sts.sqrt_busy)
        else $error("square root restarted while busy");

    a_take_comb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> o_cmd.comb)
        else $error("comb step did not follow sample transfer");

    a_store_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sq_start |=> i_sts.sqrt_busy)
        else $error("square root did not start");
`endif

endmodule

// File: test/sliding_dft_two_tone_detector_test.sv
module sliding_dft_two_tone_detector_test;
    import sdtd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Block sizes used by the DUT and the predictor.
    localparam int WinLen = WindowLenDef;
    localparam int BlkLen = BlockLenDef;
    localparam int SettleCycles = 200;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [SampleW-1:0]      i_sample;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_tone_high;
    logic                    o_diff_valid;
    logic signed [DiffW-1:0] o_level_diff;
    logic                    o_block_end;
    logic                    o_buffer_select;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CfgIdxW-1:0]      i_cfg_index;
    logic [CfgDataW-1:0]     i_cfg_data;

    sliding_dft_two_tone_detector u_dut (.*);

    // One detector result: the tone bit and the decimated fields.
    typedef struct packed {
        logic                    tone;
        logic                    dvalid;
        logic signed [DiffW-1:0] diff;
        logic                    bend;
        logic                    bsel;
    } t_detect;

    t_detect detect_fifo[$];
    int      err_count;

    // Predictor copy of configuration and state.
    logic [GainW-1:0]    gain_q;
    logic [63:0]         coef_q[NumRes];
    logic [DecimW-1:0]   decim_q;
    logic [SampleW-1:0]  hist_q[WinLen];
    int                  hist_ptr;
    longint              acc_re[NumRes];
    longint              acc_im[NumRes];
    int                  phase_q;
    int                  blk_cnt;
    bit                  buf_q;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("sliding_dft_two_tone_detector_test NOT OK");
        $finish;
    end

    function automatic longint fl_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // (p1 + p2) / 2^30 rounded half up, without overflowing 64 bits.
    function automatic longint rnd_q30(longint p1, longint p2);
        longint h1, h2, l1, l2;
        h1 = fl_shr(p1, 30);
        h2 = fl_shr(p2, 30);
        l1 = p1 - (h1 <<< 30);
        l2 = p2 - (h2 <<< 30);
        return h1 + h2 + fl_shr(l1 + l2 + (64'sd1 <<< 29), 30);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Hann-weighted magnitude of one tone (three resonators from base).
    function automatic longint tone_level(int base);
        longint nr, ni, cr, ci;
        longint unsigned sq;
        nr = 2 * acc_re[base+1] - acc_re[base] - acc_re[base+2];
        ni = 2 * acc_im[base+1] - acc_im[base] - acc_im[base+2];
        cr = fl_shr(nr + 2, 2);
        ci = fl_shr(ni + 2, 2);
        sq = longint'(cr * cr) + longint'(ci * ci);
        return longint'(int_sqrt(sq));
    endfunction

    task automatic detector_reset_model();
        gain_q = 31'h4000_0000;
        decim_q = 8'd1;
        for (int k = 0; k < NumRes; k++) begin
            coef_q[k] = '0;
            acc_re[k] = 0;
            acc_im[k] = 0;
        end
        for (int k = 0; k < WinLen; k++) hist_q[k] = '0;
        hist_ptr = 0;
        phase_q = 0;
        blk_cnt = 0;
        buf_q = 1'b0;
    endtask

    task automatic predict_detect(logic [SampleW-1:0] x);
        longint comb, br, bi, sr, si, lo, hi, d;
        longint unsigned scaled;
        int dec;
        t_detect r;
        scaled = (longint'(gain_q) * longint'(hist_q[hist_ptr]) + (64'd1 << 21)) >> 22;
        comb = (longint'(x) <<< 8) - longint'(scaled);
        for (int k = 0; k < NumRes; k++) begin
            br = longint'($signed(coef_q[k][63:32]));
            bi = longint'($signed(coef_q[k][31:0]));
            sr = acc_re[k];
            si = acc_im[k];
            acc_re[k] = clip32(comb + rnd_q30(br * sr, -(bi * si)));
            acc_im[k] = clip32(comb + rnd_q30(br * si, bi * sr));
        end
        lo = tone_level(0);
        hi = tone_level(3);
        d = hi - lo;
        if (d > 64'sd8589934591) d = 64'sd8589934591;
        if (d < -64'sd8589934592) d = -64'sd8589934592;
        r = '0;
        r.tone = d > 0;
        dec = (decim_q == 0) ? 1 : int'(decim_q);
        if (phase_q == 0) begin
            r.dvalid = 1'b1;
            r.diff = d[DiffW-1:0];
            r.bsel = buf_q;
            blk_cnt++;
            if (blk_cnt >= BlkLen) begin
                r.bend = 1'b1;
                buf_q = ~buf_q;
                blk_cnt = 0;
            end
        end
        phase_q = (phase_q + 1 >= dec) ? 0 : phase_q + 1;
        hist_q[hist_ptr] = x;
        hist_ptr = (hist_ptr + 1 >= WinLen) ? 0 : hist_ptr + 1;
        detect_fifo.push_back(r);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    // Sends one sample: random gap, then holds valid until the transfer.
    task automatic send_sample(logic [SampleW-1:0] x);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        repeat (gap) @(negedge i_clk);
        i_sample = x;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_detect(x);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COMB_GAIN:  gain_q = val[GainW-1:0];
            CFG_DECIMATION: decim_q = val[DecimW-1:0];
            default:        coef_q[int'(idx) - 1] = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Waits for all expected results, then lets the pipeline settle.
    task automatic drain();
        while (detect_fifo.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // Random coefficient: real part up to 0.984375 and imaginary part up to 0.25 in magnitude, both scaled by 2^30.
    function automatic logic [63:0] rand_coef();
        logic [31:0] re, im;
        re = $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h3F00_0000))
                                  : -32'($urandom_range(0, 32'h3F00_0000));
        im = $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h1000_0000))
                                  : -32'($urandom_range(0, 32'h1000_0000));
        return {re, im};
    endfunction

    // Receiver: random stall per result, compares each transfer.
    initial begin
        t_detect want;
        int hold;
        i_out_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            i_out_stall = hold != 0;
            repeat (hold) @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            if (detect_fifo.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = detect_fifo.pop_front();
                if (o_tone_high !== want.tone)
                    report_mismatch("tone_high", o_tone_high, want.tone);
                if (o_diff_valid !== want.dvalid)
                    report_mismatch("diff_valid", o_diff_valid, want.dvalid);
                if (o_level_diff !== want.diff)
                    report_mismatch("level_diff", o_level_diff, want.diff);
                if (o_block_end !== want.bend)
                    report_mismatch("block_end", o_block_end, want.bend);
                if (o_buffer_select !== want.bsel)
                    report_mismatch("buffer_select", o_buffer_select, want.bsel);
            end
        end
    end

    // Resonators at reset coefficients: level difference stays zero.
    task automatic test_reset_defaults();
        send_sample(8'hFF);
        send_sample(8'h00);
        send_sample(8'hAA);
        send_sample(8'h55);
        drain();
    endtask

    // Extreme coefficients and samples, including saturation of the state.
    task automatic test_extremes();
        write_reg(CFG_LOW_BELOW, 64'h7FFF_FFFF_8000_0000);
        write_reg(CFG_LOW_CENTER, 64'h4000_0000_0000_0000);
        write_reg(CFG_LOW_ABOVE, 64'h8000_0000_7FFF_FFFF);
        write_reg(CFG_HIGH_BELOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_HIGH_CENTER, 64'h8000_0000_8000_0000);
        write_reg(CFG_HIGH_ABOVE, 64'h0000_0000_4000_0000);
        write_reg(CFG_COMB_GAIN, 64'h4000_0000);
        write_reg(CFG_DECIMATION, 64'd1);
        for (int i = 0; i < 12; i++) send_sample(i[0] ? 8'hFF : 8'h00);
        drain();
        // Zero gain, decimation treated as one when zero.
        write_reg(CFG_COMB_GAIN, 64'h0);
        write_reg(CFG_DECIMATION, 64'd0);
        for (int i = 0; i < 4; i++) send_sample(8'hFF);
        drain();
        // Largest decimation, then lowered under the phase to force a wrap.
        write_reg(CFG_COMB_GAIN, 64'h7FFF_FFFF);
        write_reg(CFG_DECIMATION, 64'd255);
        for (int i = 0; i < 5; i++) send_sample(8'($urandom));
        drain();
        write_reg(CFG_DECIMATION, 64'd3);
        for (int i = 0; i < 4; i++) send_sample(8'($urandom));
        drain();
    endtask

    // Several random settings, long enough to wrap the window and blocks.
    task automatic test_random_settings();
        int n;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_COMB_GAIN, 64'($urandom_range(0, 32'h4000_0000)));
            for (int k = 1; k <= NumRes; k++) write_reg(t_cfg_idx'(k), rand_coef());
            write_reg(CFG_DECIMATION, (ph == 0) ? 64'd1 : 64'($urandom_range(1, 8)));
            n = 220;
            for (int i = 0; i < n; i++) send_sample(8'($urandom));
            drain();
        end
    endtask

    initial begin
        err_count = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_COMB_GAIN;
        i_cfg_data = '0;
        detector_reset_model();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_extremes();
        test_random_settings();
        if (err_count == 0 && detect_fifo.size() == 0) begin
            $display("sliding_dft_two_tone_detector_test OK");
        end else begin
            $display("sliding_dft_two_tone_detector_test NOT OK");
        end
        $finish;
    end
endmodule
